// ===== src/lbcc_pkg.sv =====
package lbcc_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int KEY_W = 64;
  localparam int GEN_W = 32;
  localparam int TICK_W = 64;
  localparam int SIZE_W = 32;
  localparam int HELD_W = 40;
  localparam int TRI_W = 32;
  localparam int OUT_CNT_W = 7;

  localparam logic [31:0] MIN_ITEMS = 32'd3;

  localparam logic [2:0] OP_LOOKUP  = 3'd0;
  localparam logic [2:0] OP_MISSING = 3'd1;
  localparam logic [2:0] OP_INSERT  = 3'd2;
  localparam logic [2:0] OP_EVICT   = 3'd3;
  localparam logic [2:0] OP_CLEAR   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_INELIG   = 2'd2;
  localparam logic [1:0] ST_REPLACED = 2'd3;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [GEN_W-1:0]  generation;
    logic              usable;
    logic [TICK_W-1:0] last_used;
    logic [SIZE_W-1:0] size;
  } entry_t;

  typedef struct packed {
    logic [2:0]        opcode;
    logic [KEY_W-1:0]  item_key;
    logic [GEN_W-1:0]  item_generation;
    logic              geometry_present;
    logic [31:0]       vertex_count;
    logic [31:0]       index_count;
    logic [SIZE_W-1:0] entry_size;
    logic              entry_good;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 hit;
    logic                 hit_usable;
    logic                 needs_build;
    logic [OUT_CNT_W-1:0] evicted_count;
    logic [OUT_CNT_W-1:0] entry_count;
    logic [HELD_W-1:0]    held_total;
  } rsp_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_PICK,
    FSM_PLACE,
    FSM_DONE
  } fsm_t;

endpackage

// ===== src/lru_byte_capped_cache_table.sv =====
// LRU cache table with a byte budget.
// Request channel (req_valid/req_stall/req) takes one command item: lookup,
// missing check, insert, evict to cap or clear. Response channel
// (rsp_valid/rsp_stall/rsp) returns exactly one item per command.
// Entries live in a ring of ENTRIES cells that rotates one slot per cycle
// while a pass runs (SCAN or PLACE); a single compare unit at the head cell
// sees slot i when the pass counter is i, edits it and feeds it back to the tail.
// Disabled, ineligible and unused commands go straight to DONE.
// Lookup, missing check and clear take one ring pass.
// Insert takes a scan pass, a pick step and a placement pass.
// Evict takes one pass plus one pass per removed entry, each pass followed
// by a pick step that chooses the next entry to remove or ends the command.
// One command is in flight at a time; req_stall is high while it runs.
// A finished item waits in the response register while the next command is
// taken; if rsp_stall holds the previous item, the new result waits in DONE.
// Reset invalidates all slots, zeroes the byte total and tick counter and
// loads the register defaults (enabled, 64 MiB cap, no triangle floor).
module lru_byte_capped_cache_table import lbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_CAP     = 2'd1;
  localparam logic [1:0] REG_MINTRI  = 2'd2;

  // configuration registers
  logic              enabled;
  logic [HELD_W-1:0] memory_cap;
  logic [TRI_W-1:0]  min_triangles;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled       <= 1'b1;
      memory_cap    <= HELD_W'(64'd67108864);
      min_triangles <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_ENABLED: enabled       <= pwdata[0];
        REG_CAP:     memory_cap    <= pwdata[HELD_W-1:0];
        REG_MINTRI:  min_triangles <= pwdata[TRI_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_ENABLED: prdata = {63'd0, enabled};
      REG_CAP:     prdata = {{(64-HELD_W){1'b0}}, memory_cap};
      REG_MINTRI:  prdata = {{(64-TRI_W){1'b0}}, min_triangles};
      default:     prdata = '0;
    endcase
  end

  // eligibility of the offered item: idx/3 >= m is idx >= 3*m
  logic [33:0] tri_floor;
  logic        eligible;
  logic [1:0]  acc_status;

  assign tri_floor = {1'b0, min_triangles, 1'b0} + {2'b00, min_triangles};
  assign eligible = (req.item_key != '0) && req.geometry_present &&
                    (req.vertex_count >= MIN_ITEMS) && (req.index_count >= MIN_ITEMS) &&
                    ({2'b00, req.index_count} >= tri_floor);

  always_comb begin
    acc_status = ST_OK;
    if (req.opcode == OP_LOOKUP || req.opcode == OP_MISSING || req.opcode == OP_INSERT) begin
      if (!enabled) begin
        acc_status = ST_DISABLED;
      end else if (!eligible) begin
        acc_status = ST_INELIG;
      end
    end
  end

  // FSM and control state
  fsm_t              state;
  fsm_t              state_next;
  logic              shift_en;
  logic              load_rsp;
  logic              accept;
  logic [IDX_W-1:0]  cnt;
  logic              last;

  req_t              cur;
  logic [1:0]        cur_status;
  logic [HELD_W-1:0] held;
  logic [TICK_W-1:0] use_counter;
  logic [CNT_W-1:0]  entry_cnt;
  logic [CNT_W-1:0]  evicted;
  logic              hit_r;
  logic              usable_r;

  // pass trackers
  logic              key_found;
  logic [IDX_W-1:0]  key_idx;
  logic [SIZE_W-1:0] key_size;
  logic              key_gen_eq;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;
  logic              lru_found;
  logic [IDX_W-1:0]  lru_idx;
  logic [TICK_W-1:0] lru_tick;
  logic [KEY_W-1:0]  lru_key;
  logic [SIZE_W-1:0] lru_size;
  logic              drop_pend;
  logic [IDX_W-1:0]  drop_idx;
  logic [IDX_W-1:0]  tgt;
  logic [SIZE_W-1:0] sub;

  assign accept = req_valid && !req_stall;
  assign last = (cnt == IDX_W'(ENTRIES - 1));

  // ring of cells: cell 0 is the head, the edited head re-enters at the tail
  entry_t cell_q [ENTRIES];
  entry_t cell_d [ENTRIES];
  entry_t wb;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_ring
    if (g == ENTRIES - 1) begin : g_tail
      assign cell_d[g] = wb;
    end else begin : g_mid
      assign cell_d[g] = cell_q[g+1];
    end
    lbcc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift_en),
      .d     (cell_d[g]),
      .q     (cell_q[g])
    );
  end

  // head compare unit
  entry_t h;
  logic   first;
  logic   key_hit;
  logic   gen_eq;
  logic   drop_here;
  logic   kf_prev;
  logic   ff_prev;
  logic   lf_prev;
  logic   better;

  assign h = cell_q[0];
  assign first = (cnt == '0);
  assign key_hit = h.valid && (h.key == cur.item_key);
  assign gen_eq = (h.generation == cur.item_generation);
  assign drop_here = drop_pend && (cnt == drop_idx);
  assign kf_prev = first ? 1'b0 : key_found;
  assign ff_prev = first ? 1'b0 : free_found;
  assign lf_prev = first ? 1'b0 : lru_found;
  assign better = h.valid && !drop_here &&
                  (!lf_prev || (h.last_used < lru_tick) ||
                   ((h.last_used == lru_tick) && (h.key < lru_key)));

  always_comb begin
    wb = h;
    if (state == FSM_SCAN) begin
      case (cur.opcode)
        OP_LOOKUP: if (key_hit && gen_eq) wb.last_used = use_counter + 1'b1;
        OP_EVICT:  if (drop_here) wb.valid = 1'b0;
        OP_CLEAR:  wb.valid = 1'b0;
        default: ;
      endcase
    end else if (state == FSM_PLACE && cnt == tgt) begin
      wb.valid      = 1'b1;
      wb.key        = cur.item_key;
      wb.generation = cur.item_generation;
      wb.usable     = cur.entry_good;
      wb.last_used  = use_counter + 1'b1;
      wb.size       = cur.entry_size;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          if (acc_status != ST_OK || req.opcode > OP_CLEAR) begin
            state_next = FSM_DONE;
          end else begin
            state_next = FSM_SCAN;
          end
        end
      end
      FSM_SCAN: begin
        if (last) begin
          if (cur.opcode == OP_INSERT || cur.opcode == OP_EVICT) begin
            state_next = FSM_PICK;
          end else begin
            state_next = FSM_DONE;
          end
        end
      end
      FSM_PICK: begin
        if (cur.opcode == OP_INSERT) begin
          state_next = FSM_PLACE;
        end else if (held > memory_cap && lru_found) begin
          state_next = FSM_SCAN;
        end else begin
          state_next = FSM_DONE;
        end
      end
      FSM_PLACE: begin
        if (last) state_next = FSM_DONE;
      end
      FSM_DONE: begin
        if (load_rsp) state_next = FSM_IDLE;
      end
      default: state_next = FSM_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req_stall = 1'b1;
    shift_en  = 1'b0;
    load_rsp  = 1'b0;
    unique case (state)
      FSM_IDLE:  req_stall = 1'b0;
      FSM_SCAN:  shift_en = 1'b1;
      FSM_PLACE: shift_en = 1'b1;
      FSM_DONE:  load_rsp = !rsp_valid || !rsp_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control state with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held        <= '0;
      use_counter <= '0;
      entry_cnt   <= '0;
      cnt         <= '0;
    end else begin
      if (shift_en) begin
        cnt <= last ? '0 : cnt + 1'b1;
      end
      if (state == FSM_SCAN) begin
        case (cur.opcode)
          OP_LOOKUP: if (key_hit && gen_eq) use_counter <= use_counter + 1'b1;
          OP_EVICT:  if (drop_here) entry_cnt <= entry_cnt - 1'b1;
          OP_CLEAR: begin
            if (h.valid) entry_cnt <= entry_cnt - 1'b1;
            if (last) held <= '0;
          end
          default: ;
        endcase
      end
      if (state == FSM_PICK) begin
        if (cur.opcode == OP_INSERT) begin
          if (!key_found && free_found) entry_cnt <= entry_cnt + 1'b1;
        end else if (held > memory_cap && lru_found) begin
          held <= held - HELD_W'(lru_size);
        end
      end
      if (state == FSM_PLACE && last) begin
        held        <= held - HELD_W'(sub) + HELD_W'(cur.entry_size);
        use_counter <= use_counter + 1'b1;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur        <= req;
      cur_status <= acc_status;
      hit_r      <= 1'b0;
      usable_r   <= 1'b0;
      evicted    <= '0;
      drop_pend  <= 1'b0;
      key_found  <= 1'b0;
      key_gen_eq <= 1'b0;
    end
    if (state == FSM_SCAN) begin
      key_found <= kf_prev | key_hit;
      if (key_hit && !kf_prev) begin
        key_idx    <= cnt;
        key_size   <= h.size;
        key_gen_eq <= gen_eq;
      end
      free_found <= ff_prev | !h.valid;
      if (!h.valid && !ff_prev) free_idx <= cnt;
      lru_found <= lf_prev | better;
      if (better) begin
        lru_idx  <= cnt;
        lru_tick <= h.last_used;
        lru_key  <= h.key;
        lru_size <= h.size;
      end
      if (cur.opcode == OP_LOOKUP && key_hit && gen_eq) begin
        hit_r    <= 1'b1;
        usable_r <= h.usable;
      end
      if (cur.opcode == OP_CLEAR && h.valid) evicted <= evicted + 1'b1;
    end
    if (state == FSM_PICK) begin
      if (cur.opcode == OP_INSERT) begin
        if (key_found) begin
          tgt <= key_idx;
          sub <= key_size;
        end else if (free_found) begin
          tgt <= free_idx;
          sub <= '0;
        end else begin
          tgt        <= lru_idx;
          sub        <= lru_size;
          evicted    <= CNT_W'(1);
          cur_status <= ST_REPLACED;
        end
      end else if (held > memory_cap && lru_found) begin
        evicted   <= evicted + 1'b1;
        drop_pend <= 1'b1;
        drop_idx  <= lru_idx;
      end else begin
        drop_pend <= 1'b0;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status        <= cur_status;
      rsp.hit           <= hit_r;
      rsp.hit_usable    <= usable_r;
      rsp.needs_build   <= (cur.opcode == OP_MISSING) && (cur_status == ST_OK) &&
                           !(key_found && key_gen_eq);
      rsp.evicted_count <= OUT_CNT_W'(evicted);
      rsp.entry_count   <= OUT_CNT_W'(entry_cnt);
      rsp.held_total    <= held;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_cnt <= CNT_W'(ENTRIES))
    else $error("entry count above table depth");

  a_place_insert: assert property (@(posedge clk) disable iff (rst)
    state == FSM_PLACE |-> cur.opcode == OP_INSERT)
    else $error("placement pass outside insert");

  a_evict_fits: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_PICK && state_next == FSM_DONE && cur.opcode == OP_EVICT)
      |-> (held <= memory_cap || entry_cnt == '0))
    else $error("evict finished above the byte cap");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == FSM_DONE)
    else $error("response raised outside DONE");
`endif

endmodule

// ===== src/lbcc_cell.sv =====
module lbcc_cell import lbcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   shift,
  input  entry_t d,
  output entry_t q
);

  logic   valid;
  entry_t data;

  // valid bit clears on reset; the payload is don't-care until written
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      data <= d;
    end
  end

  always_comb begin
    q = data;
    q.valid = valid;
  end

endmodule

// ===== tb/lbcc_checker.sv =====
module lbcc_checker import lbcc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] ADDR_ENABLED = 5'd0;
  localparam logic [4:0] ADDR_CAP     = 5'd8;
  localparam logic [4:0] ADDR_MINTRI  = 5'd16;

  // table mirror
  bit              tv_valid  [ENTRIES];
  bit [KEY_W-1:0]  tv_key    [ENTRIES];
  bit [GEN_W-1:0]  tv_gen    [ENTRIES];
  bit              tv_usable [ENTRIES];
  bit [TICK_W-1:0] tv_tick   [ENTRIES];
  bit [SIZE_W-1:0] tv_size   [ENTRIES];
  bit [63:0]       bytes_now;
  bit [63:0]       tick_now;

  bit              en_reg;
  bit [HELD_W-1:0] cap_reg;
  bit [TRI_W-1:0]  mintri_reg;

  rsp_t expected_rsp_q[$];

  assign pending = expected_rsp_q.size();

  function automatic bit is_eligible(req_t r);
    if (r.item_key == 0 || !r.geometry_present) return 0;
    if (r.vertex_count < 3 || r.index_count < 3) return 0;
    return (r.index_count / 3) >= mintri_reg;
  endfunction

  function automatic int slot_of_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (tv_valid[i] && tv_key[i] == k) return i;
    return -1;
  endfunction

  // oldest tick first, ties by smaller key, then lower slot
  function automatic int oldest_slot();
    int b;
    b = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tv_valid[i]) continue;
      if (b < 0 || tv_tick[i] < tv_tick[b] ||
          (tv_tick[i] == tv_tick[b] && tv_key[i] < tv_key[b]))
        b = i;
    end
    return b;
  endfunction

  function automatic void drop(int s);
    bytes_now -= tv_size[s];
    tv_valid[s] = 0;
  endfunction

  function automatic rsp_t cache_outcome(req_t r);
    rsp_t o;
    int s;
    int n;
    int ev;
    o = '0;
    ev = 0;
    if (r.opcode <= OP_INSERT) begin
      if (!en_reg) o.status = ST_DISABLED;
      else if (!is_eligible(r)) o.status = ST_INELIG;
    end
    if (r.opcode == OP_LOOKUP && o.status == ST_OK) begin
      s = slot_of_key(r.item_key);
      if (s >= 0 && tv_gen[s] == r.item_generation) begin
        o.hit = 1;
        tick_now++;
        tv_tick[s] = tick_now;
        o.hit_usable = tv_usable[s];
      end
    end else if (r.opcode == OP_MISSING && o.status == ST_OK) begin
      s = slot_of_key(r.item_key);
      o.needs_build = (s < 0 || tv_gen[s] != r.item_generation);
    end else if (r.opcode == OP_INSERT && o.status == ST_OK) begin
      s = slot_of_key(r.item_key);
      if (s >= 0) bytes_now -= tv_size[s];
      else begin
        for (int i = 0; i < ENTRIES; i++)
          if (!tv_valid[i]) begin
            s = i;
            break;
          end
        if (s < 0) begin
          s = oldest_slot();
          drop(s);
          ev = 1;
          o.status = ST_REPLACED;
        end
      end
      tv_valid[s] = 1;
      tv_key[s] = r.item_key;
      tv_gen[s] = r.item_generation;
      tv_usable[s] = r.entry_good;
      tv_size[s] = r.entry_size;
      tick_now++;
      tv_tick[s] = tick_now;
      bytes_now += r.entry_size;
    end else if (r.opcode == OP_EVICT) begin
      while (bytes_now > cap_reg) begin
        s = oldest_slot();
        if (s < 0) break;
        drop(s);
        ev++;
      end
    end else if (r.opcode == OP_CLEAR) begin
      for (int i = 0; i < ENTRIES; i++)
        if (tv_valid[i]) ev++;
      for (int i = 0; i < ENTRIES; i++) tv_valid[i] = 0;
      bytes_now = 0;
    end
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (tv_valid[i]) n++;
    o.evicted_count = (ev > 127) ? 7'd127 : ev[6:0];
    o.entry_count   = (n > 127) ? 7'd127 : n[6:0];
    o.held_total    = (bytes_now > 64'hFF_FFFF_FFFF) ? '1 : bytes_now[HELD_W-1:0];
    return o;
  endfunction

  function automatic void compare_rsp(rsp_t e, rsp_t a);
    if (e.status != a.status) begin
      $display("%0t status exp %0d got %0d", $realtime, e.status, a.status);
      fail_count++;
    end
    if (e.hit != a.hit) begin
      $display("%0t hit exp %0d got %0d", $realtime, e.hit, a.hit);
      fail_count++;
    end
    if (e.hit_usable != a.hit_usable) begin
      $display("%0t hit_usable exp %0d got %0d", $realtime, e.hit_usable, a.hit_usable);
      fail_count++;
    end
    if (e.needs_build != a.needs_build) begin
      $display("%0t needs_build exp %0d got %0d", $realtime, e.needs_build, a.needs_build);
      fail_count++;
    end
    if (e.evicted_count != a.evicted_count) begin
      $display("%0t evicted_count exp %0d got %0d", $realtime, e.evicted_count,
               a.evicted_count);
      fail_count++;
    end
    if (e.entry_count != a.entry_count) begin
      $display("%0t entry_count exp %0d got %0d", $realtime, e.entry_count, a.entry_count);
      fail_count++;
    end
    if (e.held_total != a.held_total) begin
      $display("%0t held_total exp %0d got %0d", $realtime, e.held_total, a.held_total);
      fail_count++;
    end
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) tv_valid[i] = 0;
      bytes_now = 0;
      tick_now = 0;
      en_reg = 1;
      cap_reg = 40'd67108864;
      mintri_reg = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t unexpected item: got %p", $realtime, rsp);
          fail_count++;
        end else
          compare_rsp(expected_rsp_q.pop_front(), rsp);
      end
      if (req_valid && !req_stall)
        expected_rsp_q = {expected_rsp_q, cache_outcome(req)};
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_ENABLED: en_reg = pwdata[0];
          ADDR_CAP:     cap_reg = pwdata[HELD_W-1:0];
          ADDR_MINTRI:  mintri_reg = pwdata[TRI_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
  import lbcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [4:0] ADDR_ENABLED = 5'd0;
  localparam logic [4:0] ADDR_CAP     = 5'd8;
  localparam logic [4:0] ADDR_MINTRI  = 5'd16;
  // worst item: evict of a full table, 65 ring passes, plus the long hold
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 106;

  logic        clk = 0;
  logic        rst = 1;
  logic        req_valid = 0;
  logic        req_stall;
  req_t        req = '0;
  logic        rsp_valid;
  logic        rsp_stall = 0;
  rsp_t        rsp;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int  sent_items = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  int  rx_cycle = 0;

  always #4 clk = ~clk;

  lru_byte_capped_cache_table u_top (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  lbcc_checker u_checker (
    .clk, .rst, .req_valid, .req_stall, .req, .rsp_valid, .rsp_stall, .rsp,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending
  );

  // Receiver: stall density steps through none, light and heavy in turn.
  // Once, after 150 items have gone in, stall without a break so the
  // block fills and pushes back on the sender.
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1;
    end else if (!hold_done && sent_items >= 150) begin
      hold_done = 1;
      hold_left = 399;
      rsp_stall <= 1;
    end else begin
      case ((rx_cycle / 200) % 3)
        0: rsp_stall <= 0;
        1: rsp_stall <= ($urandom_range(3) == 0);
        default: rsp_stall <= ($urandom_range(9) < 7);
      endcase
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offer one item and hold it until taken; then maybe open a gap.
  task automatic send_item(req_t r);
    int gap;
    req <= r;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    sent_items++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        req_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(logic [4:0] a, logic [63:0] d);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // Quiesce: drop valid, let every expected item come back.
  task automatic drain();
    req_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  function automatic req_t cmd(logic [2:0] op, logic [63:0] k, logic [31:0] g,
                               logic geo, logic [31:0] vc, logic [31:0] ic,
                               logic [31:0] sz, logic good);
    req_t r;
    r.opcode = op;
    r.item_key = k;
    r.item_generation = g;
    r.geometry_present = geo;
    r.vertex_count = vc;
    r.index_count = ic;
    r.entry_size = sz;
    r.entry_good = good;
    return r;
  endfunction

  // Mostly well-formed commands on a small key pool so hits, stale
  // generations, full-table replacement and evictions all happen.
  function automatic req_t random_cmd();
    req_t r;
    int p;
    p = $urandom_range(99);
    if (p < 35) r.opcode = OP_LOOKUP;
    else if (p < 55) r.opcode = OP_MISSING;
    else if (p < 87) r.opcode = OP_INSERT;
    else if (p < 95) r.opcode = OP_EVICT;
    else if (p < 97) r.opcode = OP_CLEAR;
    else r.opcode = 3'($urandom_range(5, 7));
    r.item_key = ($urandom_range(19) == 0) ? {$urandom, $urandom}
                                            : 64'($urandom_range(1, 80));
    r.item_generation = ($urandom_range(19) == 0) ? $urandom : $urandom_range(2);
    r.geometry_present = ($urandom_range(19) != 0);
    r.vertex_count = ($urandom_range(19) == 0) ? $urandom : $urandom_range(2, 200);
    r.index_count = ($urandom_range(19) == 0) ? $urandom : $urandom_range(2, 600);
    r.entry_size = ($urandom_range(29) == 0) ? $urandom : $urandom_range(4000);
    r.entry_good = $urandom_range(1);
    return r;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_item(random_cmd());
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, every opcode, ineligible cases.
    send_item(cmd(OP_INSERT, '1, '1, 1, '1, '1, '1, 1));
    send_item(cmd(OP_LOOKUP, '1, '1, 1, 3, 3, 0, 0));
    send_item(cmd(OP_LOOKUP, '1, 0, 1, 3, 3, 0, 0));          // stale generation
    send_item(cmd(OP_MISSING, '1, 0, 1, 3, 3, 0, 0));
    send_item(cmd(OP_MISSING, '1, '1, 1, 3, 3, 0, 0));
    send_item(cmd(OP_INSERT, 0, 5, 1, 9, 9, 10, 1));          // key zero
    send_item(cmd(OP_INSERT, 7, 5, 0, 9, 9, 10, 1));          // no geometry
    send_item(cmd(OP_LOOKUP, 7, 5, 1, 2, 9, 0, 0));           // too few vertices
    send_item(cmd(OP_MISSING, 7, 5, 1, 9, 2, 0, 0));          // too few indices
    send_item(cmd(OP_INSERT, 7, 0, 1, 3, 3, 0, 0));           // zero size, unusable
    send_item(cmd(OP_LOOKUP, 7, 0, 1, 3, 3, 0, 0));
    send_item(cmd(OP_INSERT, 7, 1, 1, 3, 3, 100, 1));         // replace same key
    send_item(cmd(OP_LOOKUP, 7, 1, 1, 3, 3, 0, 0));
    send_item(cmd(3'd5, 0, 0, 0, 0, 0, 0, 0));
    send_item(cmd(3'd6, 0, 0, 0, 0, 0, 0, 0));
    send_item(cmd(3'd7, '1, '1, 1, '1, '1, '1, 1));
    send_item(cmd(OP_EVICT, 0, 0, 0, 0, 0, 0, 0));
    send_item(cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(ADDR_MINTRI, 64'd4);
    send_item(cmd(OP_INSERT, 9, 0, 1, 3, 11, 5, 1));          // 3 triangles: too few
    send_item(cmd(OP_INSERT, 9, 0, 1, 3, 12, 5, 1));          // exactly enough
    drain();
    write_reg(ADDR_ENABLED, 64'd0);
    send_item(cmd(OP_LOOKUP, 9, 0, 1, 3, 12, 0, 0));
    send_item(cmd(OP_INSERT, 9, 0, 1, 3, 12, 5, 1));
    send_item(cmd(OP_EVICT, 0, 0, 0, 0, 0, 0, 0));
    drain();
    write_reg(ADDR_ENABLED, 64'd1);
    write_reg(ADDR_MINTRI, 64'd0);

    // Phases across register settings.
    run_random(PHASE_ITEMS);
    drain();
    write_reg(ADDR_CAP, 64'd20000);
    write_reg(ADDR_MINTRI, 64'd2);
    run_random(PHASE_ITEMS);
    drain();
    write_reg(ADDR_CAP, 64'd0);
    write_reg(ADDR_MINTRI, 64'd0);
    run_random(PHASE_ITEMS);
    drain();
    write_reg(ADDR_ENABLED, 64'd0);
    write_reg(ADDR_CAP, 64'hFF_FFFF_FFFF);
    run_random(PHASE_ITEMS / 3);
    drain();
    write_reg(ADDR_ENABLED, 64'd1);
    write_reg(ADDR_MINTRI, 64'hFFFF_FFFF);
    run_random(PHASE_ITEMS / 3);
    drain();
    write_reg(ADDR_MINTRI, 64'd1);
    write_reg(ADDR_CAP, 64'd100000);
    run_random(PHASE_ITEMS);

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
